/* src/nrsp_pkg.sv */
// ----------------------------------------------------------------------------
// NMEA RMC parser package
// Shared record and scan state types for the RMC sentence parser.
// ----------------------------------------------------------------------------
package nrsp_pkg;

  typedef struct packed {
    logic [2:0]  flags;
    logic [7:0]  hh;
    logic [7:0]  mi;
    logic [7:0]  ss;
    logic [15:0] ms;
    logic [7:0]  dd;
    logic [7:0]  mo;
    logic [7:0]  yy;
    logic [7:0]  lat_deg;
    logic [7:0]  lat_min;
    logic [15:0] lat_frac;
    logic [7:0]  lon_deg;
    logic [7:0]  lon_min;
    logic [15:0] lon_frac;
  } rec_t;

  typedef struct packed {
    logic       capturing;
    logic [3:0] group;
    logic [3:0] pos;
    logic       stopped;
    logic [7:0] h0;
    logic [7:0] h1;
    rec_t       rec;
  } scan_t;

endpackage

/* src/nmea_rmc_sentence_parser_unit.sv */
// ----------------------------------------------------------------------------
// NMEA RMC sentence parser
// Extracts time, fix status, position and date from RMC sentences carried
// one UART character per request.
// ----------------------------------------------------------------------------
// The input stream carries one received character per request in tdata and
// its error-free flag in tuser. Characters with the flag low are dropped.
// A sentence runs from a dollar sign to a newline; at the newline one record
// request leaves on the output stream, with the flags in tuser and the time,
// date, latitude and longitude fields packed in tdata.
// Every input request is registered, then applied to the sentence state from
// that register, and the finished record is registered again on the output.
// One character is accepted every cycle while no newline waits for the output register.
// The finished record sits in an output register; while the receiver stalls
// the block keeps taking characters, and only a second newline waits until
// that register is free.
// Sentences longer than MaxSentence characters are dropped without output.
// Reset clears the sentence state with the record being built and empties both stages.
// ----------------------------------------------------------------------------
module nmea_rmc_sentence_parser_unit #(
  parameter int MaxSentence = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,  // rx_byte[7:0]
  input  logic [0:0]   s_axis_tuser,  // rx_ok[0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,  // time[39:0], date[63:40], lat[95:64], lon[127:96]
  output logic [2:0]   m_axis_tuser   // flags[2:0]
);
  import nrsp_pkg::*;

  localparam int LenW = $clog2(MaxSentence + 1);

  logic            in_valid_q, in_valid_d;
  logic [7:0]      in_byte_q;
  logic            in_ok_q;
  scan_t           scan_q, scan_d;
  logic [LenW-1:0] len_q, len_d;
  logic            emit;
  rec_t            rec;
  logic            out_valid_q, out_valid_d;
  logic [127:0]    out_data_q;
  logic [2:0]      out_user_q;
  logic            advance;
  logic            in_take;

  nrsp_scan #(
    .MaxSentence(MaxSentence),
    .LenW       (LenW)
  ) u_scan (
    .scan_i(scan_q),
    .len_i (len_q),
    .byte_i(in_byte_q),
    .ok_i  (in_valid_q & in_ok_q),
    .scan_o(scan_d),
    .len_o (len_d),
    .emit_o(emit),
    .rec_o (rec)
  );

  assign advance       = !in_valid_q || !emit || !out_valid_q || m_axis_tready;
  assign s_axis_tready = advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign in_valid_d    = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_q);

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (in_valid_q && emit && advance) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      scan_q      <= '0;
      len_q       <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (in_valid_q && advance) begin
        scan_q <= scan_d;
        len_q  <= len_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= s_axis_tdata;
      in_ok_q   <= s_axis_tuser[0];
    end
    if (in_valid_q && emit && advance) begin
      out_user_q <= rec.flags;
      out_data_q <= {rec.lon_deg, rec.lon_min, rec.lon_frac,
                     rec.lat_deg, rec.lat_min, rec.lat_frac,
                     rec.dd, rec.mo, rec.yy,
                     rec.hh, rec.mi, rec.ss, rec.ms};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

/* src/nrsp_scan.sv */
// ----------------------------------------------------------------------------
// NMEA RMC character scanner
// Applies one received character to the sentence state and builds the
// finished record when the newline arrives.
// ----------------------------------------------------------------------------
module nrsp_scan #(
  parameter int MaxSentence = 256,
  parameter int LenW        = $clog2(MaxSentence + 1)
) (
  input  nrsp_pkg::scan_t  scan_i,
  input  logic [LenW-1:0]  len_i,
  input  logic [7:0]       byte_i,
  input  logic             ok_i,
  output nrsp_pkg::scan_t  scan_o,
  output logic [LenW-1:0]  len_o,
  output logic             emit_o,
  output nrsp_pkg::rec_t   rec_o
);
  import nrsp_pkg::*;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_A       = 8'h41;
  localparam logic [7:0] CH_N       = 8'h4E;
  localparam logic [7:0] CH_E       = 8'h45;
  localparam logic [7:0] DIGIT_BASE = 8'd48;
  localparam logic [7:0] DIGIT_NUL  = 8'(CH_NUL - DIGIT_BASE);

  localparam logic [3:0] GRP_TIME   = 4'd1;
  localparam logic [3:0] GRP_STATUS = 4'd2;
  localparam logic [3:0] GRP_LAT    = 4'd3;
  localparam logic [3:0] GRP_NS     = 4'd4;
  localparam logic [3:0] GRP_LON    = 4'd5;
  localparam logic [3:0] GRP_EW     = 4'd6;
  localparam logic [3:0] GRP_DATE   = 4'd9;
  localparam logic [3:0] GRP_MAX    = 4'd15;

  localparam int FLAG_FIX   = 0;
  localparam int FLAG_NORTH = 1;
  localparam int FLAG_EAST  = 2;

  function automatic logic [3:0] field_len(logic [3:0] grp);
    logic [3:0] len;
    unique case (grp)
      GRP_TIME:   len = 4'd10;
      GRP_STATUS: len = 4'd1;
      GRP_LAT:    len = 4'd9;
      GRP_NS:     len = 4'd1;
      GRP_LON:    len = 4'd10;
      GRP_EW:     len = 4'd1;
      GRP_DATE:   len = 4'd6;
      default:    len = 4'd0;
    endcase
    return len;
  endfunction

  function automatic logic [15:0] tens(logic [7:0] h, logic [7:0] d);
    return 16'(h) * 16'd10 + 16'(d);
  endfunction

  function automatic logic [15:0] hundreds(logic [7:0] h0, logic [7:0] h1, logic [7:0] d);
    return 16'(h0) * 16'd100 + tens(h1, d);
  endfunction

  function automatic logic [7:0] two8(logic [7:0] h, logic [7:0] d);
    logic [15:0] t;
    t = tens(h, d);
    return t[7:0];
  endfunction

  function automatic scan_t scan_char(scan_t s, logic [7:0] c);
    scan_t       n;
    logic [7:0]  d;
    logic [15:0] t16;
    logic [15:0] h3;
    logic [3:0]  grp;
    n   = s;
    d   = c - DIGIT_BASE;
    t16 = tens(s.h1, d);
    h3  = hundreds(s.h0, s.h1, d);
    grp = (s.group < GRP_MAX) ? s.group + 4'd1 : s.group;
    if (!s.stopped) begin
      if (s.pos == 4'd0) begin
        if (c == CH_NUL) begin
          n.stopped = 1'b1;
        end else if (c == CH_COMMA) begin
          n.group = grp;
          n.pos   = (field_len(grp) != 4'd0) ? 4'd1 : 4'd0;
        end
      end else begin
        case (s.group)
          GRP_TIME: begin
            case (s.pos)
              4'd2:    n.rec.hh = t16[7:0];
              4'd4:    n.rec.mi = t16[7:0];
              4'd6:    n.rec.ss = t16[7:0];
              4'd7:    ;
              4'd8:    n.h0 = d;
              4'd10:   n.rec.ms = h3;
              default: n.h1 = d;
            endcase
          end
          GRP_STATUS: n.rec.flags[FLAG_FIX] = (c == CH_A);
          GRP_LAT: begin
            case (s.pos)
              4'd2:    n.rec.lat_deg = t16[7:0];
              4'd4:    n.rec.lat_min = t16[7:0];
              4'd5:    ;
              4'd7:    n.rec.lat_frac = t16 * 16'd100;
              4'd9:    n.rec.lat_frac = s.rec.lat_frac + t16;
              default: n.h1 = d;
            endcase
          end
          GRP_NS: n.rec.flags[FLAG_NORTH] = (c == CH_N);
          GRP_LON: begin
            case (s.pos)
              4'd1:    n.h0 = d;
              4'd3:    n.rec.lon_deg = h3[7:0];
              4'd5:    n.rec.lon_min = t16[7:0];
              4'd6:    ;
              4'd8:    n.rec.lon_frac = t16 * 16'd100;
              4'd10:   n.rec.lon_frac = s.rec.lon_frac + t16;
              default: n.h1 = d;
            endcase
          end
          GRP_EW: n.rec.flags[FLAG_EAST] = (c == CH_E);
          GRP_DATE: begin
            case (s.pos)
              4'd2:    n.rec.dd = t16[7:0];
              4'd4:    n.rec.mo = t16[7:0];
              4'd6:    n.rec.yy = t16[7:0];
              default: n.h1 = d;
            endcase
          end
          default: ;
        endcase
        n.pos = s.pos + 4'd1;
        if (n.pos > field_len(s.group)) begin
          n.pos = 4'd0;
        end
      end
    end
    return n;
  endfunction

  // The rest of an open field is filled with NUL characters at the newline.
  function automatic rec_t flush_rec(scan_t s);
    rec_t        r;
    logic [3:0]  p;
    logic [15:0] t;
    r = s.rec;
    p = s.pos;
    t = '0;
    if (p != 4'd0) begin
      case (s.group)
        GRP_TIME: begin
          if (p <= 4'd2) r.hh = two8((p < 4'd2) ? DIGIT_NUL : s.h1, DIGIT_NUL);
          if (p <= 4'd4) r.mi = two8((p < 4'd4) ? DIGIT_NUL : s.h1, DIGIT_NUL);
          if (p <= 4'd6) r.ss = two8((p < 4'd6) ? DIGIT_NUL : s.h1, DIGIT_NUL);
          r.ms = hundreds((p <= 4'd8) ? DIGIT_NUL : s.h0,
                          (p <= 4'd9) ? DIGIT_NUL : s.h1, DIGIT_NUL);
        end
        GRP_STATUS: r.flags[FLAG_FIX] = 1'b0;
        GRP_LAT: begin
          if (p <= 4'd2) r.lat_deg = two8((p < 4'd2) ? DIGIT_NUL : s.h1, DIGIT_NUL);
          if (p <= 4'd4) r.lat_min = two8((p < 4'd4) ? DIGIT_NUL : s.h1, DIGIT_NUL);
          t = (p <= 4'd7)
              ? tens((p < 4'd7) ? DIGIT_NUL : s.h1, DIGIT_NUL) * 16'd100
              : s.rec.lat_frac;
          r.lat_frac = t + tens((p < 4'd9) ? DIGIT_NUL : s.h1, DIGIT_NUL);
        end
        GRP_NS: r.flags[FLAG_NORTH] = 1'b0;
        GRP_LON: begin
          if (p <= 4'd3) begin
            t = hundreds((p <= 4'd1) ? DIGIT_NUL : s.h0,
                         (p <= 4'd2) ? DIGIT_NUL : s.h1, DIGIT_NUL);
            r.lon_deg = t[7:0];
          end
          if (p <= 4'd5) r.lon_min = two8((p < 4'd5) ? DIGIT_NUL : s.h1, DIGIT_NUL);
          t = (p <= 4'd8)
              ? tens((p < 4'd8) ? DIGIT_NUL : s.h1, DIGIT_NUL) * 16'd100
              : s.rec.lon_frac;
          r.lon_frac = t + tens((p < 4'd10) ? DIGIT_NUL : s.h1, DIGIT_NUL);
        end
        GRP_EW: r.flags[FLAG_EAST] = 1'b0;
        GRP_DATE: begin
          if (p <= 4'd2) r.dd = two8((p < 4'd2) ? DIGIT_NUL : s.h1, DIGIT_NUL);
          if (p <= 4'd4) r.mo = two8((p < 4'd4) ? DIGIT_NUL : s.h1, DIGIT_NUL);
          if (p <= 4'd6) r.yy = two8((p < 4'd6) ? DIGIT_NUL : s.h1, DIGIT_NUL);
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  scan_t stepped;

  always_comb begin
    stepped = scan_char(scan_i, byte_i);
    scan_o  = scan_i;
    len_o   = len_i;
    emit_o  = 1'b0;
    rec_o   = '0;
    if (ok_i) begin
      if (!scan_i.capturing) begin
        if (byte_i == CH_DOLLAR) begin
          scan_o.capturing = 1'b1;
          scan_o.group     = '0;
          scan_o.pos       = '0;
          scan_o.stopped   = 1'b0;
          scan_o.h0        = '0;
          scan_o.h1        = '0;
          len_o            = LenW'(1);
        end
      end else if (byte_i != CH_DOLLAR) begin
        if (len_i >= LenW'(MaxSentence)) begin
          scan_o = '0;
          len_o  = '0;
        end else begin
          scan_o = stepped;
          len_o  = len_i + LenW'(1);
          if (byte_i == CH_NL) begin
            emit_o = 1'b1;
            rec_o  = flush_rec(stepped);
            scan_o = '0;
            len_o  = '0;
          end
        end
      end
    end
  end

endmodule
